@@ hw/rtl/rekd_pkg.sv @@
// Shared types, codes and constants for the rotary encoder and key debounce block.
`timescale 1ns / 1ps

package rekd_pkg;

    // Width of the internal detent counter; the result carries its low POS_W bits
    localparam int COUNT_WIDTH = 16;
    localparam int POS_W       = 16;
    localparam int CNT_EXT_W   = (COUNT_WIDTH > POS_W) ? COUNT_WIDTH : POS_W;

    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 8;
    localparam int TMR_W     = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_HOLD_TICKS = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] DEBOUNCE_TICKS_RST = CFG_W'(20);
    localparam logic [CFG_W-1:0] DIR_HOLD_TICKS_RST = CFG_W'(10);

    // Rotation direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_CCW  = 2'd1;
    localparam logic [1:0] DIR_CW   = 2'd2;

    // Encoder phase codes, A in the high bit
    localparam logic [1:0] AB_REST  = 2'b00;
    localparam logic [1:0] AB_B_LED = 2'b01;
    localparam logic [1:0] AB_A_LED = 2'b10;

    // Key state codes
    localparam logic [1:0] KEY_IDLE       = 2'd0;
    localparam logic [1:0] KEY_DB_PRESS   = 2'd1;
    localparam logic [1:0] KEY_PRESSED    = 2'd2;
    localparam logic [1:0] KEY_DB_RELEASE = 2'd3;

    typedef struct packed {
        logic signed [POS_W-1:0] position_count;
        logic [1:0]              rotation_direction;
        logic [1:0]              key_state;
        logic                    press_event;
    } t_result;

    // Take the low POS_W bits of the counter, zero-extending a narrow one
    function automatic logic [POS_W-1:0] count_to_pos(input logic [COUNT_WIDTH-1:0] cnt);
        logic [CNT_EXT_W-1:0] ext;
        ext = CNT_EXT_W'(cnt);
        return ext[POS_W-1:0];
    endfunction

endpackage

@@ hw/rtl/rekd_in_if.sv @@
// Input channel: one poll tick of raw encoder and switch levels per beat.
`timescale 1ns / 1ps

interface rekd_in_if;
    logic valid;
    logic ready;
    logic phase_a;
    logic phase_b;
    logic switch_level;

    modport source (output valid, output phase_a, output phase_b, output switch_level,
                    input ready);
    modport sink   (input valid, input phase_a, input phase_b, input switch_level,
                    output ready);
endinterface

@@ hw/rtl/rekd_out_if.sv @@
// Output channel: count, direction and key status per beat.
`timescale 1ns / 1ps

interface rekd_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [rekd_pkg::POS_W-1:0]   position_count;
    logic [1:0]                          rotation_direction;
    logic [1:0]                          key_state;
    logic                                press_event;

    modport source (output valid, output position_count, output rotation_direction,
                    output key_state, output press_event, input ready);
    modport sink   (input valid, input position_count, input rotation_direction,
                    input key_state, input press_event, output ready);
endinterface

@@ hw/rtl/rekd_quad.sv @@
// Quadrature decoder: detent counter, direction report and hold timer.
`timescale 1ns / 1ps

module rekd_quad (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_fire,
    input  logic                              i_phase_a,
    input  logic                              i_phase_b,
    input  logic [rekd_pkg::CFG_W-1:0]        i_hold_ticks,
    output logic [rekd_pkg::POS_W-1:0]        o_position,
    output logic [1:0]                        o_direction
);
    import rekd_pkg::*;

    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [1:0]             r_prev_ab;
    logic [1:0]             r_dir, n_dir;
    logic [TMR_W-1:0]       r_tmr, n_tmr;
    logic [1:0]             ab;
    logic                   step_cw, step_ccw;
    logic [1:0]             dir_step;
    logic [TMR_W-1:0]       tmr_step, tmr_inc;

    assign ab       = {i_phase_a, i_phase_b};
    assign step_ccw = (r_prev_ab == AB_REST) && (ab == AB_B_LED);
    assign step_cw  = (r_prev_ab == AB_REST) && (ab == AB_A_LED);

    // Count a detent out of rest, then age the reported direction
    always_comb begin
        n_count  = r_count;
        dir_step = r_dir;
        tmr_step = r_tmr;
        if (step_cw) begin
            n_count  = r_count + COUNT_WIDTH'(1);
            dir_step = DIR_CW;
            tmr_step = '0;
        end else if (step_ccw) begin
            n_count  = r_count - COUNT_WIDTH'(1);
            dir_step = DIR_CCW;
            tmr_step = '0;
        end
        tmr_inc = tmr_step + TMR_W'(1);
        n_dir   = dir_step;
        n_tmr   = tmr_step;
        if (dir_step != DIR_NONE) begin
            if (tmr_inc >= i_hold_ticks) begin
                n_dir = DIR_NONE;
                n_tmr = '0;
            end else begin
                n_tmr = tmr_inc;
            end
        end
    end

    // Advance state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_prev_ab <= AB_REST;
            r_dir     <= DIR_NONE;
            r_tmr     <= '0;
        end else if (i_fire) begin
            r_count   <= n_count;
            r_prev_ab <= ab;
            r_dir     <= n_dir;
            r_tmr     <= n_tmr;
        end
    end

    assign o_position  = count_to_pos(n_count);
    assign o_direction = n_dir;

    // The hold timer only runs while a direction is reported
    a_tmr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dir == DIR_NONE) |-> (r_tmr == '0))
        else $error("hold timer running with no direction");

    // A counted clockwise detent reports its direction on the same beat when the hold exceeds one tick
    a_step_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && step_cw && i_hold_ticks > TMR_W'(1)) |-> (o_direction == DIR_CW))
        else $error("clockwise detent not reported");

endmodule

@@ hw/rtl/rekd_key.sv @@
// Push switch debounce machine with press pulse.
`timescale 1ns / 1ps

module rekd_key (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic                        i_switch_level,
    input  logic [rekd_pkg::CFG_W-1:0]  i_debounce_ticks,
    output logic [1:0]                  o_state,
    output logic                        o_press
);
    import rekd_pkg::*;

    logic [1:0]       r_state, n_state;
    logic [TMR_W-1:0] r_cnt, n_cnt;
    logic [TMR_W-1:0] cnt_inc;
    logic             pressed;
    logic             pulse;

    assign pressed = !i_switch_level;
    assign cnt_inc = r_cnt + TMR_W'(1);

    // Next state of the debounce machine
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        pulse   = 1'b0;
        unique case (r_state)
            KEY_IDLE: begin
                if (pressed) begin
                    n_state = KEY_DB_PRESS;
                    n_cnt   = '0;
                end
            end
            KEY_DB_PRESS: begin
                if (pressed) begin
                    n_cnt = cnt_inc;
                    if (cnt_inc >= i_debounce_ticks) begin
                        n_state = KEY_PRESSED;
                        pulse   = 1'b1;
                    end
                end else begin
                    n_state = KEY_IDLE;
                end
            end
            KEY_PRESSED: begin
                if (!pressed) begin
                    n_state = KEY_DB_RELEASE;
                    n_cnt   = '0;
                end
            end
            default: begin
                if (!pressed) begin
                    n_cnt = cnt_inc;
                    if (cnt_inc >= i_debounce_ticks) begin
                        n_state = KEY_IDLE;
                    end
                end else begin
                    n_state = KEY_PRESSED;
                end
            end
        endcase
    end

    // Advance on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= KEY_IDLE;
            r_cnt   <= '0;
        end else if (i_fire) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_state = n_state;
    assign o_press = pulse;

    // A press pulse comes only from the debounce-press state
    a_press_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_press |-> (r_state == KEY_DB_PRESS && o_state == KEY_PRESSED))
        else $error("press pulse outside debounce-press exit");

endmodule

@@ hw/rtl/rekd_obuf.sv @@
// Two-entry output buffer: result register plus skid register.
`timescale 1ns / 1ps

module rekd_obuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  rekd_pkg::t_result  i_data,
    output logic               o_ready,
    output logic               o_valid,
    output rekd_pkg::t_result  o_data,
    input  logic               i_ready
);
    import rekd_pkg::*;

    logic    r_out_v, r_skid_v;
    t_result r_out, r_skid;
    logic    in_fire, out_fire;

    assign o_ready  = !r_skid_v;
    assign in_fire  = i_valid && !r_skid_v;
    assign out_fire = r_out_v && i_ready;

    // Control: refill the result slot from skid first, else from the input
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || out_fire) begin
            r_out_v  <= r_skid_v || in_fire;
            r_skid_v <= 1'b0;
        end else if (in_fire) begin
            r_skid_v <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (!r_out_v || out_fire) begin
            r_out <= r_skid_v ? r_skid : i_data;
        end else if (in_fire) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // Skid holds a beat only behind a held result
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry without result entry");

    // A full buffer keeps its skid beat until the result drains
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_ready) |=> (r_skid_v && r_out_v))
        else $error("skid beat lost while stalled");

endmodule

@@ hw/rtl/rotary_encoder_with_key_debounce.sv @@
// Top level: rotary encoder decoder with push switch debounce.
// One poll tick is accepted per clock unless the skid register is full; each
// tick yields one result beat in the output register, or the skid register
// while stalled. Every state update is a single short pass (one 16-bit add,
// two 8-bit compares) between the accepted beat and the result register, and
// a two-entry output buffer lets input flow on for one beat while the output
// is stalled; throughput is one tick per clock while the sink takes results.
// Configuration writes (debounce length, direction hold) take effect on the
// next accepted tick; no clearing pass is needed after reset.
`timescale 1ns / 1ps

module rotary_encoder_with_key_debounce (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rekd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rekd_pkg::CFG_W-1:0]      i_cfg_data,
    rekd_in_if.sink                         i_in,
    rekd_out_if.source                      o_out
);
    import rekd_pkg::*;

    logic [CFG_W-1:0] r_debounce_ticks;
    logic [CFG_W-1:0] r_hold_ticks;
    logic             fire;
    logic             buf_ready;
    t_result          result;
    t_result          out_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= DEBOUNCE_TICKS_RST;
            r_hold_ticks     <= DIR_HOLD_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEBOUNCE_TICKS: r_debounce_ticks <= i_cfg_data;
                CFG_DIR_HOLD_TICKS: r_hold_ticks     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_in.ready = buf_ready;
    assign fire       = i_in.valid && buf_ready;

    rekd_quad u_quad (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_phase_a    (i_in.phase_a),
        .i_phase_b    (i_in.phase_b),
        .i_hold_ticks (r_hold_ticks),
        .o_position   (result.position_count),
        .o_direction  (result.rotation_direction)
    );

    rekd_key u_key (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (fire),
        .i_switch_level   (i_in.switch_level),
        .i_debounce_ticks (r_debounce_ticks),
        .o_state          (result.key_state),
        .o_press          (result.press_event)
    );

    rekd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_data  (result),
        .o_ready (buf_ready),
        .o_valid (o_out.valid),
        .o_data  (out_data),
        .i_ready (o_out.ready)
    );

    // Drive the output beat
    assign o_out.position_count     = out_data.position_count;
    assign o_out.rotation_direction = out_data.rotation_direction;
    assign o_out.key_state          = out_data.key_state;
    assign o_out.press_event        = out_data.press_event;

endmodule

@@ tb/rotary_encoder_with_key_debounce_tb.sv @@
// Self-checking testbench for the rotary encoder decoder with push switch debounce.
`timescale 1ns / 1ps

module rotary_encoder_with_key_debounce_tb;
    import rekd_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLDOFF  = 300;

    // Both channels high: third quarter of a detent, never counted
    localparam logic [1:0]           AB_BOTH        = 2'b11;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = CFG_IDX_W'(2);

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    rekd_in_if  tick_if ();
    rekd_out_if status_if ();

    rotary_encoder_with_key_debounce dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (tick_if.sink),
        .o_out      (status_if.source)
    );

    // Shadow copy of the block's registers and state
    logic [CFG_W-1:0]       cfg_bounce;
    logic [CFG_W-1:0]       cfg_hold;
    logic [COUNT_WIDTH-1:0] pos_cnt;
    logic [1:0]             last_ab;
    logic [1:0]             dir_now;
    logic [TMR_W-1:0]       hold_tmr;
    logic [1:0]             key_now;
    logic [TMR_W-1:0]       bounce_cnt;

    t_result knob_status_q[$];

    int  fail_cnt = 0;
    int  cycle_cnt = 0;
    bit  tx_idle_en;
    bit  rx_idle_en;
    bit  holdoff_req;
    int  holdoff_left = 0;
    int  rx_burst_left = 0;
    bit  rx_burst_stall;

    // Stimulus generator state
    logic [1:0] enc_idx;
    bit         enc_cw;
    int         enc_dwell;
    logic       sw_level;
    int         sw_run;

    // Clock: 10 ns period
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("rotary_encoder_with_key_debounce verification failed");
            $finish;
        end
    end

    // Advance the shadow state by one poll tick and return the status it yields
    function automatic t_result knob_status_after(input logic a, input logic b,
                                                  input logic sw);
        logic [1:0] ab;
        logic       pressed;
        t_result    r;
        ab            = {a, b};
        pressed       = !sw;
        r.press_event = 1'b0;

        // Count only steps out of the rest position
        if (last_ab == AB_REST) begin
            if (ab == AB_B_LED) begin
                pos_cnt  = pos_cnt - 1'b1;
                dir_now  = DIR_CCW;
                hold_tmr = '0;
            end else if (ab == AB_A_LED) begin
                pos_cnt  = pos_cnt + 1'b1;
                dir_now  = DIR_CW;
                hold_tmr = '0;
            end
        end
        last_ab = ab;

        // Age the reported direction
        if (dir_now != DIR_NONE) begin
            hold_tmr = hold_tmr + 1'b1;
            if (hold_tmr >= cfg_hold) begin
                dir_now  = DIR_NONE;
                hold_tmr = '0;
            end
        end

        case (key_now)
            KEY_IDLE: begin
                if (pressed) begin
                    key_now    = KEY_DB_PRESS;
                    bounce_cnt = '0;
                end
            end
            KEY_DB_PRESS: begin
                if (pressed) begin
                    bounce_cnt = bounce_cnt + 1'b1;
                    if (bounce_cnt >= cfg_bounce) begin
                        key_now       = KEY_PRESSED;
                        r.press_event = 1'b1;
                    end
                end else begin
                    key_now = KEY_IDLE;
                end
            end
            KEY_PRESSED: begin
                if (!pressed) begin
                    key_now    = KEY_DB_RELEASE;
                    bounce_cnt = '0;
                end
            end
            default: begin
                if (!pressed) begin
                    bounce_cnt = bounce_cnt + 1'b1;
                    if (bounce_cnt >= cfg_bounce)
                        key_now = KEY_IDLE;
                end else begin
                    key_now = KEY_PRESSED;
                end
            end
        endcase

        r.position_count     = POS_W'(pos_cnt);
        r.rotation_direction = dir_now;
        r.key_state          = key_now;
        return r;
    endfunction

    // Drive the sink ready: long hold-off on request, else random stall bursts if enabled, else always ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            status_if.ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            status_if.ready <= 1'b0;
        end else if (holdoff_req) begin
            holdoff_req  = 1'b0;
            holdoff_left = LONG_HOLDOFF;
            status_if.ready <= 1'b0;
        end else if (rx_idle_en) begin
            if (rx_burst_left == 0) begin
                rx_burst_left  = $urandom_range(1, 16);
                rx_burst_stall = ($urandom_range(0, 2) == 0);
            end
            rx_burst_left--;
            status_if.ready <= !rx_burst_stall;
        end else begin
            status_if.ready <= 1'b1;
        end
    end

    // Compare every status beat with the oldest prediction
    always @(posedge i_clk) begin
        t_result exp_st;
        if (i_rst_n === 1'b1 && status_if.valid === 1'b1 && status_if.ready === 1'b1) begin
            if (knob_status_q.size() == 0) begin
                $display("%0t: unexpected status beat, expected none, got count %0d dir %0d",
                         $time, status_if.position_count, status_if.rotation_direction);
                fail_cnt++;
            end else begin
                exp_st = knob_status_q.pop_front();
                if (status_if.position_count !== exp_st.position_count) begin
                    $display("%0t: position_count expected %0d, actual %0d", $time,
                             exp_st.position_count, status_if.position_count);
                    fail_cnt++;
                end
                if (status_if.rotation_direction !== exp_st.rotation_direction) begin
                    $display("%0t: rotation_direction expected %0d, actual %0d", $time,
                             exp_st.rotation_direction, status_if.rotation_direction);
                    fail_cnt++;
                end
                if (status_if.key_state !== exp_st.key_state) begin
                    $display("%0t: key_state expected %0d, actual %0d", $time,
                             exp_st.key_state, status_if.key_state);
                    fail_cnt++;
                end
                if (status_if.press_event !== exp_st.press_event) begin
                    $display("%0t: press_event expected %0b, actual %0b", $time,
                             exp_st.press_event, status_if.press_event);
                    fail_cnt++;
                end
            end
        end
    end

    // Offer one poll tick, optionally after a gap, and hold until taken
    task automatic send_tick(input logic a, input logic b, input logic sw);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            tick_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        tick_if.valid        <= 1'b1;
        tick_if.phase_a      <= a;
        tick_if.phase_b      <= b;
        tick_if.switch_level <= sw;
        do @(posedge i_clk); while (tick_if.ready !== 1'b1);
        knob_status_q.push_back(knob_status_after(a, b, sw));
    endtask

    // Drop valid and wait until every predicted beat has come out
    task automatic wait_drained();
        tick_if.valid <= 1'b0;
        while (knob_status_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_DEBOUNCE_TICKS)
            cfg_bounce = val;
        else if (idx == CFG_DIR_HOLD_TICKS)
            cfg_hold = val;
        @(posedge i_clk);
    endtask

    // One tick of a mostly well-formed rotation walk and a bouncy switch
    task automatic random_tick();
        logic [1:0] ab;
        if (enc_dwell > 0) begin
            enc_dwell--;
        end else begin
            case ($urandom_range(0, 9))
                0: enc_idx = 2'($urandom_range(0, 3));
                1: begin
                    enc_cw  = !enc_cw;
                    enc_idx = enc_cw ? enc_idx + 1'b1 : enc_idx - 1'b1;
                end
                default: enc_idx = enc_cw ? enc_idx + 1'b1 : enc_idx - 1'b1;
            endcase
            enc_dwell = ($urandom_range(0, 7) == 0) ? $urandom_range(0, int'(cfg_hold) + 4)
                                                    : $urandom_range(0, 2);
        end
        case (enc_idx)
            2'd0:    ab = AB_REST;
            2'd1:    ab = AB_A_LED;
            2'd2:    ab = AB_BOTH;
            default: ab = AB_B_LED;
        endcase

        // Toggle the switch after a run, short runs act as contact bounce
        if (sw_run == 0) begin
            sw_level = !sw_level;
            sw_run   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(1, int'(cfg_bounce) + 8);
        end else begin
            sw_run--;
        end
        send_tick(ab[1], ab[0], sw_level);
    endtask

    task automatic apply_reset();
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    // Detent steps both ways, uncounted moves and every key transition
    task automatic test_basic_ticks();
        write_reg(CFG_DEBOUNCE_TICKS, CFG_W'(1));
        write_reg(CFG_DIR_HOLD_TICKS, CFG_W'(3));
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);
    endtask

    // Zero lengths and a write to an index that does not exist
    task automatic test_register_corners();
        wait_drained();
        write_reg(CFG_DEBOUNCE_TICKS, CFG_W'(0));
        write_reg(CFG_DIR_HOLD_TICKS, CFG_W'(0));
        write_reg(CFG_UNUSED_IDX, CFG_W'(8'h55));
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
    endtask

    task automatic test_random_config(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] hold,
                                      input int n_ticks);
        wait_drained();
        write_reg(CFG_DEBOUNCE_TICKS, deb);
        write_reg(CFG_DIR_HOLD_TICKS, hold);
        repeat (n_ticks) random_tick();
    endtask

    // Stall the sink for a long stretch while ticks keep coming
    task automatic test_input_backpressure();
        bit saved_idle;
        saved_idle  = tx_idle_en;
        tx_idle_en  = 1'b0;
        holdoff_req = 1'b1;
        repeat (80) random_tick();
        tx_idle_en = saved_idle;
    endtask

    initial begin
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        holdoff_req   = 1'b0;
        enc_idx       = 2'd0;
        enc_cw        = 1'b1;
        enc_dwell     = 0;
        sw_level      = 1'b1;
        sw_run        = 0;
        cfg_bounce    = DEBOUNCE_TICKS_RST;
        cfg_hold      = DIR_HOLD_TICKS_RST;
        pos_cnt       = '0;
        last_ab       = AB_REST;
        dir_now       = DIR_NONE;
        hold_tmr      = '0;
        key_now       = KEY_IDLE;
        bounce_cnt    = '0;

        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= '0;
        i_cfg_data           <= '0;
        tick_if.valid        <= 1'b0;
        tick_if.phase_a      <= 1'b0;
        tick_if.phase_b      <= 1'b0;
        tick_if.switch_level <= 1'b1;

        apply_reset();
        test_basic_ticks();
        test_register_corners();
        test_random_config(CFG_W'(4), CFG_W'(6), 200);
        test_random_config(CFG_W'(255), CFG_W'(255), 400);
        test_random_config(CFG_W'(1), CFG_W'(1), 180);
        test_random_config(CFG_W'($urandom_range(1, 255)), CFG_W'($urandom_range(1, 255)), 200);
        test_input_backpressure();

        // Run the last stretch at full rate on both sides
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_config(DEBOUNCE_TICKS_RST, DIR_HOLD_TICKS_RST, 200);

        wait_drained();
        if (fail_cnt == 0) begin
            $display("rotary_encoder_with_key_debounce verification clean");
        end else begin
            $display("rotary_encoder_with_key_debounce verification failed");
        end
        $finish;
    end

endmodule
